// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the sdi_checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check expr at every clock edge outside reset.
`define SDI_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sdi assertion failed");

// Check that cons holds on the edge after ante.
`define SDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdi assertion failed");

`endif

// ----- rtl/core/sdi_pkg.sv -----
// ---------------------------------------------------------------------------
// sdi_pkg
// Types and constants of the SD card bring-up sequencer.
// ---------------------------------------------------------------------------
package sdi_pkg;

    // Command indexes
    localparam logic [5:0] CMD_GO_IDLE         = 6'd0;
    localparam logic [5:0] CMD_SEND_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_APP             = 6'd55;
    localparam logic [5:0] CMD_SD_SEND_OP_COND = 6'd41;
    localparam logic [5:0] CMD_ALL_SEND_CID    = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA        = 6'd3;
    localparam logic [5:0] CMD_SELECT_CARD     = 6'd7;

    localparam logic MODE_START = 1'b0;

    localparam int PADDR_W       = 4;
    localparam int OCR_READY_BIT = 31;
    localparam int OCR_CCS_BIT   = 30;

    localparam logic [31:0] ERR_MASK  = 32'hFFFF_FFFE;
    localparam logic [8:0]  ECHO_MASK = 9'h1FF;

    localparam logic [15:0] RETRY_LIMIT_RST = 16'd1000;
    localparam logic [31:0] OP_COND_RST     = 32'h4030_0000;
    localparam logic [11:0] IF_COND_RST     = 12'h1AA;

    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_PATTERN   = 2'd1,
        CAUSE_CMD_ERROR = 2'd2,
        CAUSE_TIMEOUT   = 2'd3
    } cause_t;

    typedef enum logic [1:0] {
        REG_RETRY_LIMIT = 2'd0,
        REG_OP_COND     = 2'd1,
        REG_IF_COND     = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [15:0] retry_limit;
        logic [31:0] op_cond_argument;
        logic [11:0] if_cond_argument;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] status_word;
        logic [31:0] response_word;
    } item_t;

    typedef struct packed {
        logic        issue_command;
        logic [5:0]  command_index;
        logic [31:0] command_argument;
        logic        finished;
        logic        succeeded;
        logic        high_capacity;
        logic [15:0] card_address;
        cause_t      failure_cause;
    } result_t;

endpackage

// ----- rtl/core/sdi_in_if.sv -----
// ---------------------------------------------------------------------------
// sdi_in_if
// Event channel: start requests and command completions.
// ---------------------------------------------------------------------------
interface sdi_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] status_word;
    logic [31:0] response_word;

    modport source (output valid, output mode, output status_word, output response_word,
                    input ready);
    modport sink   (input valid, input mode, input status_word, input response_word,
                    output ready);
endinterface

// ----- rtl/core/sdi_out_if.sv -----
// ---------------------------------------------------------------------------
// sdi_out_if
// Result channel: next command and sequence outcome.
// ---------------------------------------------------------------------------
interface sdi_out_if;
    logic        valid;
    logic        ready;
    logic        issue_command;
    logic [5:0]  command_index;
    logic [31:0] command_argument;
    logic        finished;
    logic        succeeded;
    logic        high_capacity;
    logic [15:0] card_address;
    logic [1:0]  failure_cause;

    modport source (output valid, output issue_command, output command_index,
                    output command_argument, output finished, output succeeded,
                    output high_capacity, output card_address, output failure_cause,
                    input ready);
    modport sink   (input valid, input issue_command, input command_index,
                    input command_argument, input finished, input succeeded,
                    input high_capacity, input card_address, input failure_cause,
                    output ready);
endinterface

// ----- rtl/core/sdi_apb_regs.sv -----
// ---------------------------------------------------------------------------
// sdi_apb_regs
// APB register file: retry limit, ACMD41 argument, CMD8 argument.
// ---------------------------------------------------------------------------
module sdi_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output sdi_pkg::cfg_t               cfg
);
    import sdi_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[PADDR_W-1:2]);
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit      <= RETRY_LIMIT_RST;
            cfg_reg.op_cond_argument <= OP_COND_RST;
            cfg_reg.if_cond_argument <= IF_COND_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_RETRY_LIMIT: cfg_reg.retry_limit      <= pwdata[15:0];
                REG_OP_COND:     cfg_reg.op_cond_argument <= pwdata;
                REG_IF_COND:     cfg_reg.if_cond_argument <= pwdata[11:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_RETRY_LIMIT: prdata = {16'd0, cfg_reg.retry_limit};
            REG_OP_COND:     prdata = cfg_reg.op_cond_argument;
            REG_IF_COND:     prdata = {20'd0, cfg_reg.if_cond_argument};
            default:         prdata = 32'd0;
        endcase
    end
endmodule

// ----- rtl/core/sdi_seq_core.sv -----
// ---------------------------------------------------------------------------
// sdi_seq_core
// Bring-up state machine: one event in, next command or outcome out.
// ---------------------------------------------------------------------------
module sdi_seq_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  sdi_pkg::item_t   item,
    input  sdi_pkg::cfg_t    cfg,
    output sdi_pkg::result_t result
);
    import sdi_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CMD0   = 4'd1,
        PH_CMD8   = 4'd2,
        PH_CMD55  = 4'd3,
        PH_ACMD41 = 4'd4,
        PH_CMD2   = 4'd5,
        PH_CMD3   = 4'd6,
        PH_CMD7   = 4'd7,
        PH_DONE   = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] attempt_reg, attempt_next;
    logic        capacity_reg, capacity_next;
    logic [15:0] rca_reg, rca_next;

    logic        err;
    logic [15:0] limit;
    logic [15:0] attempt_inc;
    logic        echo_bad;

    assign err         = (item.status_word & ERR_MASK) != 32'd0;
    assign limit       = (cfg.retry_limit == 16'd0) ? 16'd1 : cfg.retry_limit;
    assign attempt_inc = (attempt_reg != 16'hFFFF) ? attempt_reg + 16'd1 : attempt_reg;
    assign echo_bad    = (item.response_word[8:0] & ECHO_MASK)
                      != (cfg.if_cond_argument[8:0] & ECHO_MASK);

    always_comb
    begin
        phase_next    = phase_reg;
        attempt_next  = attempt_reg;
        capacity_next = capacity_reg;
        rca_next      = rca_reg;
        result.issue_command    = 1'b0;
        result.command_index    = CMD_GO_IDLE;
        result.command_argument = 32'd0;
        result.finished         = 1'b0;
        result.succeeded        = 1'b0;
        result.failure_cause    = CAUSE_NONE;

        if (item.mode == MODE_START)
        begin
            attempt_next  = 16'd0;
            capacity_next = 1'b0;
            rca_next      = 16'd0;
            phase_next    = PH_CMD0;
            result.issue_command = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_CMD0:
                begin
                    phase_next = PH_CMD8;
                    result.issue_command    = 1'b1;
                    result.command_index    = CMD_SEND_IF_COND;
                    result.command_argument = {20'd0, cfg.if_cond_argument};
                end
                PH_CMD8:
                begin
                    // An error here means a v1 card: keep going.
                    if (!err && echo_bad)
                    begin
                        phase_next = PH_DONE;
                        result.finished      = 1'b1;
                        result.failure_cause = CAUSE_PATTERN;
                    end
                    else
                    begin
                        attempt_next = 16'd0;
                        phase_next   = PH_CMD55;
                        result.issue_command = 1'b1;
                        result.command_index = CMD_APP;
                    end
                end
                PH_CMD55:
                begin
                    if (err)
                    begin
                        phase_next = PH_DONE;
                        result.finished      = 1'b1;
                        result.failure_cause = CAUSE_CMD_ERROR;
                    end
                    else
                    begin
                        phase_next = PH_ACMD41;
                        result.issue_command    = 1'b1;
                        result.command_index    = CMD_SD_SEND_OP_COND;
                        result.command_argument = cfg.op_cond_argument;
                    end
                end
                PH_ACMD41:
                begin
                    if (err)
                    begin
                        phase_next = PH_DONE;
                        result.finished      = 1'b1;
                        result.failure_cause = CAUSE_CMD_ERROR;
                    end
                    else if (item.response_word[OCR_READY_BIT])
                    begin
                        capacity_next = item.response_word[OCR_CCS_BIT];
                        phase_next    = PH_CMD2;
                        result.issue_command = 1'b1;
                        result.command_index = CMD_ALL_SEND_CID;
                    end
                    else
                    begin
                        // Card still busy: count the attempt, retry or time out.
                        attempt_next = attempt_inc;
                        if (attempt_inc >= limit)
                        begin
                            phase_next = PH_DONE;
                            result.finished      = 1'b1;
                            result.failure_cause = CAUSE_TIMEOUT;
                        end
                        else
                        begin
                            phase_next = PH_CMD55;
                            result.issue_command = 1'b1;
                            result.command_index = CMD_APP;
                        end
                    end
                end
                PH_CMD2:
                begin
                    if (err)
                    begin
                        phase_next = PH_DONE;
                        result.finished      = 1'b1;
                        result.failure_cause = CAUSE_CMD_ERROR;
                    end
                    else
                    begin
                        phase_next = PH_CMD3;
                        result.issue_command = 1'b1;
                        result.command_index = CMD_SEND_RCA;
                    end
                end
                PH_CMD3:
                begin
                    if (err)
                    begin
                        phase_next = PH_DONE;
                        result.finished      = 1'b1;
                        result.failure_cause = CAUSE_CMD_ERROR;
                    end
                    else
                    begin
                        rca_next   = item.response_word[31:16];
                        phase_next = PH_CMD7;
                        result.issue_command    = 1'b1;
                        result.command_index    = CMD_SELECT_CARD;
                        result.command_argument = {item.response_word[31:16], 16'd0};
                    end
                end
                PH_CMD7:
                begin
                    phase_next = PH_DONE;
                    result.finished = 1'b1;
                    if (err)
                    begin
                        result.failure_cause = CAUSE_CMD_ERROR;
                    end
                    else
                    begin
                        result.succeeded = 1'b1;
                    end
                end
                default:
                begin
                    // Idle or finished: drop the completion.
                end
            endcase
        end

        result.high_capacity = capacity_next;
        result.card_address  = rca_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            attempt_reg  <= 16'd0;
            capacity_reg <= 1'b0;
            rca_reg      <= 16'd0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            attempt_reg  <= attempt_next;
            capacity_reg <= capacity_next;
            rca_reg      <= rca_next;
        end
    end
endmodule

// ----- rtl/core/sd_card_init_sequencer.sv -----
// ---------------------------------------------------------------------------
// sd_card_init_sequencer
// SD card bring-up sequencer: CMD0, CMD8, CMD55/ACMD41 loop, CMD2, CMD3, CMD7.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+------------------------------------------
//  req      | in  | valid / ready   | mode, status_word, response_word
//  rsp      | out | valid / ready   | issue_command .. failure_cause
//  apb      | in  | psel / penable  | paddr, pwdata, prdata (pready tied high)
//
//  An accepted event is held in the input register, then goes through the
//  state machine into the result register. One event is accepted every
//  cycle while the result side keeps up; the state machine update is the
//  combinational step between the two registers.
//  A stall on rsp holds both registers; req.ready drops only when both are full.
//  Reset clears the phase, counters and both valid flags and loads the configuration defaults.
// ---------------------------------------------------------------------------
module sd_card_init_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    sdi_in_if.sink                      req,
    sdi_out_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sdi_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result_next;
    result_t result_reg;
    logic    rsp_valid_reg;
    logic    advance;
    logic    step_en;

    sdi_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdi_seq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result_next)
    );

    // Result register frees up when empty or being taken.
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign step_en   = advance && in_valid_reg;
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.mode          <= req.mode;
            item_reg.status_word   <= req.status_word;
            item_reg.response_word <= req.response_word;
        end
        if (step_en)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.issue_command    = result_reg.issue_command;
    assign rsp.command_index    = result_reg.command_index;
    assign rsp.command_argument = result_reg.command_argument;
    assign rsp.finished         = result_reg.finished;
    assign rsp.succeeded        = result_reg.succeeded;
    assign rsp.high_capacity    = result_reg.high_capacity;
    assign rsp.card_address     = result_reg.card_address;
    assign rsp.failure_cause    = result_reg.failure_cause;
endmodule

// ----- rtl/core/sdi_checker.sv -----
// ---------------------------------------------------------------------------
// sdi_checker
// Port-level checks on the result channel of the bring-up sequencer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sdi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        issue_command,
    input logic [5:0]  command_index,
    input logic [31:0] command_argument,
    input logic        finished,
    input logic        succeeded,
    input logic [1:0]  failure_cause
);
    import sdi_pkg::*;

    // A pending result stays up until taken.
    `SDI_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    `SDI_ASSERT_ALWAYS(a_issue_xor_finish, clk, rst_n, !rsp_valid || !(issue_command && finished))

    `SDI_ASSERT_ALWAYS(a_idle_cmd_zero, clk, rst_n, !rsp_valid || issue_command || (command_index == CMD_GO_IDLE && command_argument == 32'd0))

    `SDI_ASSERT_ALWAYS(a_success_clean, clk, rst_n, !rsp_valid || !succeeded || (finished && failure_cause == CAUSE_NONE))

    `SDI_ASSERT_ALWAYS(a_fail_has_cause, clk, rst_n, !rsp_valid || (finished == (succeeded || failure_cause != CAUSE_NONE)))
endmodule

bind sd_card_init_sequencer sdi_checker u_sdi_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .issue_command    (rsp.issue_command),
    .command_index    (rsp.command_index),
    .command_argument (rsp.command_argument),
    .finished         (rsp.finished),
    .succeeded        (rsp.succeeded),
    .failure_cause    (rsp.failure_cause)
);

// ----- test/sdi_bringup_checker.sv -----
// ----------------------------------------------------------------------------
// sdi_bringup_checker
// Watches the event, result and register ports of the SD card bring-up
// sequencer. It keeps its own copy of the sequence state and the registers,
// predicts the next command or the outcome for every accepted event, and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module sdi_bringup_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    sdi_in_if                           req,
    sdi_out_if                          rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [sdi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output int                          fail_count,
    output int                          outstanding,
    output int                          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import sdi_pkg::*;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_GO_IDLE,
        SEQ_IF_COND,
        SEQ_APP,
        SEQ_OP_COND,
        SEQ_CID,
        SEQ_RCA,
        SEQ_SELECT,
        SEQ_DONE
    } seq_phase_t;

    logic [15:0] retry_limit;
    logic [31:0] op_cond;
    logic [11:0] if_cond;

    seq_phase_t  seq;
    logic [15:0] tries;
    logic        ccs;
    logic [15:0] rca;

    result_t     awaited_replies[$];

    // Send a command and move to the phase that waits for its completion.
    function automatic result_t order_cmd(logic [5:0] idx, logic [31:0] arg,
                                          seq_phase_t next);
        result_t r;
        r                  = '0;
        r.issue_command    = 1'b1;
        r.command_index    = idx;
        r.command_argument = arg;
        seq                = next;
        return r;
    endfunction

    function automatic result_t close_seq(logic ok, cause_t cause);
        result_t r;
        r               = '0;
        r.finished      = 1'b1;
        r.succeeded     = ok;
        r.failure_cause = cause;
        seq             = SEQ_DONE;
        return r;
    endfunction

    function automatic result_t bringup_step(item_t ev);
        result_t     r;
        logic        err;
        logic [15:0] limit;
        r     = '0;
        err   = |(ev.status_word & ERR_MASK);
        limit = (retry_limit == 16'd0) ? 16'd1 : retry_limit;
        if (ev.mode == MODE_START)
        begin
            tries = '0;
            ccs   = 1'b0;
            rca   = '0;
            r     = order_cmd(CMD_GO_IDLE, '0, SEQ_GO_IDLE);
        end
        else
        begin
            case (seq)
                SEQ_GO_IDLE:
                    r = order_cmd(CMD_SEND_IF_COND, 32'(if_cond), SEQ_IF_COND);
                SEQ_IF_COND:
                    // an error here means a v1 card, only a clean reply must echo
                    if (!err && (ev.response_word[8:0] & ECHO_MASK) !=
                                (if_cond[8:0] & ECHO_MASK))
                        r = close_seq(1'b0, CAUSE_PATTERN);
                    else
                    begin
                        tries = '0;
                        r     = order_cmd(CMD_APP, '0, SEQ_APP);
                    end
                SEQ_APP:
                    r = err ? close_seq(1'b0, CAUSE_CMD_ERROR)
                            : order_cmd(CMD_SD_SEND_OP_COND, op_cond, SEQ_OP_COND);
                SEQ_OP_COND:
                    if (err)
                        r = close_seq(1'b0, CAUSE_CMD_ERROR);
                    else if (ev.response_word[OCR_READY_BIT])
                    begin
                        ccs = ev.response_word[OCR_CCS_BIT];
                        r   = order_cmd(CMD_ALL_SEND_CID, '0, SEQ_CID);
                    end
                    else
                    begin
                        if (tries != 16'hFFFF)
                            tries++;
                        r = (tries >= limit) ? close_seq(1'b0, CAUSE_TIMEOUT)
                                             : order_cmd(CMD_APP, '0, SEQ_APP);
                    end
                SEQ_CID:
                    r = err ? close_seq(1'b0, CAUSE_CMD_ERROR)
                            : order_cmd(CMD_SEND_RCA, '0, SEQ_RCA);
                SEQ_RCA:
                    if (err)
                        r = close_seq(1'b0, CAUSE_CMD_ERROR);
                    else
                    begin
                        rca = ev.response_word[31:16];
                        r   = order_cmd(CMD_SELECT_CARD, {rca, 16'h0000}, SEQ_SELECT);
                    end
                SEQ_SELECT:
                    r = err ? close_seq(1'b0, CAUSE_CMD_ERROR)
                            : close_seq(1'b1, CAUSE_NONE);
                default:
                    r = '0;
            endcase
        end
        r.high_capacity = ccs;
        r.card_address  = rca;
        return r;
    endfunction

    function automatic string describe(result_t r);
        return $sformatf("issue=%0b idx=%0d arg=%h fin=%0b ok=%0b hc=%0b rca=%h cause=%0d",
                         r.issue_command, r.command_index, r.command_argument,
                         r.finished, r.succeeded, r.high_capacity, r.card_address,
                         r.failure_cause);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_t   ev;
        result_t want;
        result_t seen;
        if (!rst_n)
        begin
            retry_limit = RETRY_LIMIT_RST;
            op_cond     = OP_COND_RST;
            if_cond     = IF_COND_RST;
            seq         = SEQ_IDLE;
            tries       = '0;
            ccs         = 1'b0;
            rca         = '0;
            awaited_replies.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[PADDR_W-1:2]))
                    REG_RETRY_LIMIT: retry_limit = pwdata[15:0];
                    REG_OP_COND:     op_cond     = pwdata;
                    REG_IF_COND:     if_cond     = pwdata[11:0];
                    default:         ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                ev = {req.mode, req.status_word, req.response_word};
                awaited_replies.push_back(bringup_step(ev));
            end
            if (rsp.valid && rsp.ready)
            begin
                seen = {rsp.issue_command, rsp.command_index, rsp.command_argument,
                        rsp.finished, rsp.succeeded, rsp.high_capacity,
                        rsp.card_address, rsp.failure_cause};
                if (awaited_replies.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing outstanding: %s",
                                 $realtime, describe(seen));
                    fail_count++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    checked++;
                    if (seen !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    predicted %s", describe(want));
                            $display("    observed  %s", describe(seen));
                        end
                        fail_count++;
                    end
                end
            end
        end
        outstanding = awaited_replies.size();
    end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the SD card bring-up sequencer with start requests and command
// completions: a directed opening through most branches of the sequence, then
// randomized bring-up attempts under a series of register settings, with
// random stalls on both channels. A separate checker predicts every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sdi_pkg::*;

    localparam logic MODE_COMPLETION = ~MODE_START;
    localparam int   PHASES          = 8;
    localparam int   PHASE_EVENTS    = 122;
    localparam int   STALL_LIMIT     = 1000;
    localparam int   OPENING_LEN     = 25;

    localparam item_t OPENING [OPENING_LEN] = '{
        {MODE_COMPLETION, 32'hFFFF_FFFF, 32'hFFFF_FFFF},   // completion while idle
        {MODE_START,      32'h0000_0000, 32'h0000_0000},
        {MODE_COMPLETION, 32'hFFFF_FFFF, 32'h0000_0000},   // go-idle status is ignored
        {MODE_COMPLETION, 32'h0000_0001, 32'h0000_01AA},   // echo matches
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_0000},
        {MODE_COMPLETION, 32'h0000_0001, 32'h7FFF_FFFF},   // card still busy
        {MODE_COMPLETION, 32'h0000_0000, 32'hFFFF_FFFF},
        {MODE_COMPLETION, 32'h0000_0000, 32'hC0FF_8000},   // ready, high capacity
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_0000},
        {MODE_COMPLETION, 32'h0000_0000, 32'hFFFF_0000},   // largest card address
        {MODE_COMPLETION, 32'h0000_0001, 32'h0000_0000},   // card selected
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_0000},   // completion after the end
        {MODE_START,      32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_0000},
        {MODE_COMPLETION, 32'h8000_0000, 32'h0000_0000},   // v1 card, no if-cond reply
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_0000},
        {MODE_COMPLETION, 32'h0000_0000, 32'h8000_0000},   // ready, standard capacity
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_0000},
        {MODE_START,      32'h0000_0000, 32'h0000_0000},   // restart mid-sequence
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_0000},
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_00AA},   // echo mismatch
        {MODE_START,      32'h0000_0000, 32'h0000_0000},
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_0000},
        {MODE_COMPLETION, 32'h0000_0000, 32'h0000_01AA},
        {MODE_COMPLETION, 32'h0000_0002, 32'h0000_0000}    // app command rejected
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int                 fail_count;
    int                 outstanding;
    int                 checked;

    int                 events_sent;
    int                 attempts;
    int                 settings;
    int                 src_idle_pct;
    int                 snk_idle_pct;
    logic [15:0]        cur_limit;
    logic [11:0]        cur_if_cond;

    sdi_in_if  req ();
    sdi_out_if rsp ();

    sd_card_init_sequencer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sdi_bringup_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] ok_status();
        return 32'($urandom_range(0, 1));
    endfunction

    function automatic logic [31:0] err_status();
        return $urandom | (32'h2 << $urandom_range(0, 30));
    endfunction

    function automatic bit fault();
        return $urandom_range(0, 15) == 0;
    endfunction

    // Present one event and hold it until the block takes the transaction.
    task automatic post_event(logic mode, logic [31:0] status, logic [31:0] resp);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.mode          <= mode;
        req.status_word   <= status;
        req.response_word <= resp;
        do @(posedge clk); while (!req.ready);
        events_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic await_idle();
        req.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One card bring-up with random content and occasional faults.
    task automatic bringup_attempt();
        logic [31:0] word;
        int          pick;
        int          busy_replies;
        int          polls;
        bit          ended;
        attempts++;
        post_event(MODE_START, $urandom, $urandom);
        post_event(MODE_COMPLETION, $urandom, $urandom);
        pick  = $urandom_range(0, 9);
        word  = $urandom;
        ended = 1'b0;
        if (pick == 0)
        begin
            word[8:0] = cur_if_cond[8:0] ^ 9'($urandom_range(1, 511));
            post_event(MODE_COMPLETION, ok_status(), word);
            ended = 1'b1;
        end
        else if (pick <= 2)
            post_event(MODE_COMPLETION, err_status(), word);
        else
        begin
            word[8:0] = cur_if_cond[8:0];
            post_event(MODE_COMPLETION, ok_status(), word);
        end
        if (!ended && $urandom_range(0, 19) == 0)
            return;
        busy_replies = $urandom_range(0, 6);
        polls        = 0;
        while (!ended)
        begin
            if (fault())
            begin
                post_event(MODE_COMPLETION, err_status(), $urandom);
                ended = 1'b1;
            end
            else
            begin
                post_event(MODE_COMPLETION, ok_status(), $urandom);
                if (fault())
                begin
                    post_event(MODE_COMPLETION, err_status(), $urandom);
                    ended = 1'b1;
                end
                else if (polls < busy_replies)
                begin
                    post_event(MODE_COMPLETION, ok_status(), $urandom & 32'h7FFF_FFFF);
                    polls++;
                    ended = polls >= ((cur_limit == 16'd0) ? 1 : int'(cur_limit));
                end
                else
                begin
                    post_event(MODE_COMPLETION, ok_status(), $urandom | 32'h8000_0000);
                    break;
                end
            end
        end
        if (!ended && $urandom_range(0, 19) == 0)
            return;
        // identification, address and select commands
        for (int k = 0; k < 3 && !ended; k++)
        begin
            if (fault())
            begin
                post_event(MODE_COMPLETION, err_status(), $urandom);
                ended = 1'b1;
            end
            else
                post_event(MODE_COMPLETION, ok_status(), $urandom);
        end
        if ($urandom_range(0, 7) == 0)
            post_event(MODE_COMPLETION, $urandom, $urandom);
    endtask

    initial
    begin : result_sink
        int hold;
        hold = 0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < snk_idle_pct)
            begin
                hold = $urandom_range(1, 10) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, outstanding);
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        logic [15:0] lim;
        logic [31:0] op;
        logic [11:0] ifc;
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.mode          <= MODE_START;
        req.status_word   <= '0;
        req.response_word <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        events_sent        = 0;
        attempts           = 0;
        settings           = 0;
        src_idle_pct       = 20;
        snk_idle_pct       = 20;
        cur_limit          = RETRY_LIMIT_RST;
        cur_if_cond        = IF_COND_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING[i])
            post_event(OPENING[i].mode, OPENING[i].status_word, OPENING[i].response_word);
        await_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lim = 16'd0;
                    op  = 32'h0000_0000;
                    ifc = 12'h000;
                end
                1:
                begin
                    lim = 16'd1;
                    op  = 32'hFFFF_FFFF;
                    ifc = 12'hFFF;
                end
                2:
                begin
                    lim = 16'hFFFF;
                    op  = OP_COND_RST;
                    ifc = IF_COND_RST;
                end
                default:
                begin
                    lim = 16'($urandom_range(1, 6));
                    op  = $urandom;
                    ifc = 12'($urandom_range(0, 4095));
                end
            endcase
            write_reg(REG_RETRY_LIMIT, 32'(lim));
            write_reg(REG_OP_COND, op);
            write_reg(REG_IF_COND, 32'(ifc));
            cur_limit   = lim;
            cur_if_cond = ifc;
            settings++;
            // vary the stall pattern, and keep the last phase free of stalls
            case (p % 3)
                0:       begin src_idle_pct = 0;  snk_idle_pct = 30; end
                1:       begin src_idle_pct = 25; snk_idle_pct = 0;  end
                default: begin src_idle_pct = 20; snk_idle_pct = 20; end
            endcase
            if (p == PHASES - 1)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            while (events_sent < OPENING_LEN + (p + 1) * PHASE_EVENTS)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(3, 12))
                        post_event(1'($urandom_range(0, 1)), $urandom, $urandom);
                else
                    bringup_attempt();
            end
            await_idle();
        end

        repeat (8) @(posedge clk);
        $display("%0d events, %0d random bring-up attempts, %0d register settings",
                 events_sent, attempts, settings);
        $display("%0d results compared, %0d mismatches, %0d still outstanding",
                 checked, fail_count, outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
